// ===== hdl/srsm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsm_pkg
// shared widths, register map and types of the serial register read master
// ----------------------------------------------------------------------------
package srsm_pkg;

  localparam int unsigned BitsPerByte = 8;
  localparam int unsigned HalfW       = 10;
  localparam int unsigned PauseW      = 12;
  localparam int unsigned TickW       = 12;
  localparam int unsigned BitIdxW     = 4;
  localparam int unsigned AddrW       = 4;
  localparam int unsigned DataW       = 32;

  localparam logic [HalfW-1:0]  HalfReset    = 10'd25;
  localparam logic [PauseW-1:0] WrPauseReset = 12'd100;
  localparam logic [PauseW-1:0] RwPauseReset = 12'd250;

  typedef enum logic [1:0] {
    RegHalfPeriod = 2'd0,
    RegWrPause    = 2'd1,
    RegRwPause    = 2'd2,
    RegNone       = 2'd3
  } reg_idx_e;

  typedef logic signed [BitsPerByte-1:0] motion_t;

endpackage

// ===== hdl/srsm_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsm_in_if / srsm_out_if
// valid/ready channels carrying one tick word in and one pin/result word out
// ----------------------------------------------------------------------------
interface srsm_in_if;
  logic       valid;
  logic       ready;
  logic       start_req;
  logic [7:0] command;
  logic       data_in;

  modport source (output valid, start_req, command, data_in, input ready);
  modport sink   (input valid, start_req, command, data_in, output ready);
endinterface

interface srsm_out_if;
  logic             valid;
  logic             ready;
  logic             clock_out;
  logic             data_out;
  logic             data_drive;
  logic             busy_res;
  logic             done_res;
  srsm_pkg::motion_t motion;

  modport source (output valid, clock_out, data_out, data_drive, busy_res, done_res, motion,
                  input ready);
  modport sink   (input valid, clock_out, data_out, data_drive, busy_res, done_res, motion,
                  output ready);
endinterface

// ===== hdl/sensor_register_read_serial_master.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_register_read_serial_master
// two-wire half-duplex master: sends a command byte, reads back one byte
//
//   channel  dir  handshake            word
//   in_i     in   valid/ready          start_req, command, data_in (one tick)
//   out_o    out  valid/ready          clock_out, data_out, data_drive,
//                                      busy_res, done_res, motion
//   apb      in   psel/penable/pready  half period, write/read pause, read/write pause
//
// one tick word is accepted per clock cycle while the output register can take
// it; its pin word appears in the output register in the next cycle, and the
// tick counter and phase update is the only path between the two registers
// a stalled output holds its word and blocks input only while it stays full
// reset gives phase idle, zero counters, registers at their reset values
// ----------------------------------------------------------------------------
module sensor_register_read_serial_master (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  srsm_in_if.sink                             in_i,
  srsm_out_if.source                          out_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [srsm_pkg::AddrW-1:0]          paddr,
  input  logic [srsm_pkg::DataW-1:0]          pwdata,
  output logic [srsm_pkg::DataW-1:0]          prdata,
  output logic                                pready
);

  localparam logic [2:0] PhIdle    = 3'd0;
  localparam logic [2:0] PhWrite   = 3'd1;
  localparam logic [2:0] PhWrPause = 3'd2;
  localparam logic [2:0] PhRead    = 3'd3;
  localparam logic [2:0] PhRwPause = 3'd4;

  localparam int unsigned TW = srsm_pkg::TickW;
  localparam int unsigned BW = srsm_pkg::BitIdxW;
  localparam int unsigned NB = srsm_pkg::BitsPerByte;

  logic [srsm_pkg::HalfW-1:0]  half_q;
  logic [srsm_pkg::PauseW-1:0] wr_pause_q;
  logic [srsm_pkg::PauseW-1:0] rw_pause_q;

  logic [2:0]    phase_q, phase_d;
  logic [BW-1:0] bit_q, bit_d;
  logic [TW-1:0] tick_q, tick_d;
  logic          high_q, high_d;
  logic [NB-1:0] shift_q, shift_d;
  logic [NB-1:0] motion_q, motion_d;

  logic [2:0]    ph0;
  logic          start_go;
  logic [BW-1:0] bit0;
  logic [TW-1:0] tick0;
  logic          high0;
  logic [NB-1:0] shift0;
  logic [TW:0]   tick_inc;
  logic [srsm_pkg::HalfW-1:0] half_len;
  logic          half_end;
  logic [BW-1:0] bit_inc;
  logic [NB-1:0] shift_rd;

  logic r_clk, r_dout, r_drive, r_busy, r_done;

  logic                    accept;
  logic                    out_valid_q;
  logic                    wr_en;
  srsm_pkg::reg_idx_e      wr_idx;

  // configuration port
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign wr_idx = srsm_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q     <= srsm_pkg::HalfReset;
      wr_pause_q <= srsm_pkg::WrPauseReset;
      rw_pause_q <= srsm_pkg::RwPauseReset;
    end else if (wr_en) begin
      case (wr_idx)
        srsm_pkg::RegHalfPeriod: half_q     <= pwdata[srsm_pkg::HalfW-1:0];
        srsm_pkg::RegWrPause:    wr_pause_q <= pwdata[srsm_pkg::PauseW-1:0];
        srsm_pkg::RegRwPause:    rw_pause_q <= pwdata[srsm_pkg::PauseW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (wr_idx)
      srsm_pkg::RegHalfPeriod: prdata = {{(srsm_pkg::DataW-srsm_pkg::HalfW){1'b0}}, half_q};
      srsm_pkg::RegWrPause:    prdata = {{(srsm_pkg::DataW-srsm_pkg::PauseW){1'b0}}, wr_pause_q};
      srsm_pkg::RegRwPause:    prdata = {{(srsm_pkg::DataW-srsm_pkg::PauseW){1'b0}}, rw_pause_q};
      default:                 prdata = '0;
    endcase
  end

  // handshake
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  // start handling
  assign start_go = (ph0 == PhIdle) && in_i.start_req;
  always_comb begin
    if (phase_q inside {[PhIdle:PhRwPause]}) begin
      ph0 = phase_q;
    end else begin
      ph0 = PhIdle;
    end
  end
  assign bit0   = start_go ? '0 : bit_q;
  assign tick0  = start_go ? '0 : tick_q;
  assign high0  = start_go ? 1'b0 : high_q;
  assign shift0 = start_go ? in_i.command : shift_q;

  assign half_len = (half_q == '0) ? {{(srsm_pkg::HalfW-1){1'b0}}, 1'b1} : half_q;
  assign tick_inc = {1'b0, tick0} + {{TW{1'b0}}, 1'b1};
  assign half_end = tick_inc >= {{(TW+1-srsm_pkg::HalfW){1'b0}}, half_len};
  assign bit_inc  = bit0 + {{(BW-1){1'b0}}, 1'b1};
  assign shift_rd = (high0 && tick0 == '0) ? {shift0[NB-2:0], in_i.data_in} : shift0;

  always_comb begin
    phase_d  = start_go ? PhWrite : ph0;
    bit_d    = bit0;
    tick_d   = tick0;
    high_d   = high0;
    shift_d  = shift0;
    motion_d = motion_q;
    r_clk    = 1'b1;
    r_dout   = 1'b0;
    r_drive  = 1'b1;
    r_busy   = 1'b1;
    r_done   = 1'b0;
    case (start_go ? PhWrite : ph0)
      PhWrite: begin
        r_clk  = high0;
        r_dout = shift0[NB-1];
        if (half_end) begin
          tick_d = '0;
          high_d = !high0;
          if (high0) begin
            shift_d = {shift0[NB-2:0], 1'b0};
            bit_d   = bit_inc;
            if (bit_inc >= BW'(NB)) begin
              if (wr_pause_q == '0) begin
                phase_d = PhRead;
                bit_d   = '0;
                shift_d = '0;
              end else begin
                phase_d = PhWrPause;
              end
            end
          end
        end else begin
          tick_d = tick_inc[TW-1:0];
        end
      end
      PhWrPause: begin
        r_drive = 1'b0;
        if (tick_inc >= {1'b0, wr_pause_q}) begin
          phase_d = PhRead;
          tick_d  = '0;
          high_d  = 1'b0;
          bit_d   = '0;
          shift_d = '0;
        end else begin
          tick_d = tick_inc[TW-1:0];
        end
      end
      PhRead: begin
        r_drive = 1'b0;
        r_clk   = high0;
        shift_d = shift_rd;
        if (half_end) begin
          tick_d = '0;
          high_d = !high0;
          if (high0) begin
            bit_d = bit_inc;
            if (bit_inc >= BW'(NB)) begin
              motion_d = shift_rd;
              r_done   = 1'b1;
              phase_d  = (rw_pause_q == '0) ? PhIdle : PhRwPause;
            end
          end
        end else begin
          tick_d = tick_inc[TW-1:0];
        end
      end
      PhRwPause: begin
        if (tick_inc >= {1'b0, rw_pause_q}) begin
          tick_d  = '0;
          phase_d = PhIdle;
        end else begin
          tick_d = tick_inc[TW-1:0];
        end
      end
      default: begin
        r_busy = 1'b0;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      bit_q    <= '0;
      tick_q   <= '0;
      high_q   <= 1'b0;
      shift_q  <= '0;
      motion_q <= '0;
    end else if (accept) begin
      phase_q  <= phase_d;
      bit_q    <= bit_d;
      tick_q   <= tick_d;
      high_q   <= high_d;
      shift_q  <= shift_d;
      motion_q <= motion_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_o.clock_out  <= r_clk;
      out_o.data_out   <= r_dout;
      out_o.data_drive <= r_drive;
      out_o.busy_res   <= r_busy;
      out_o.done_res   <= r_done;
      out_o.motion     <= srsm_pkg::motion_t'(motion_d);
    end
  end

  assign out_o.valid = out_valid_q;

endmodule

// ===== hdl/srsm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsm_checker
// port-level checks of the serial register read master, bound to the top
// ----------------------------------------------------------------------------
module srsm_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic              clock_out_i,
  input logic              data_out_i,
  input logic              data_drive_i,
  input logic              busy_res_i,
  input logic              done_res_i,
  input srsm_pkg::motion_t motion_i
);

  // stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(motion_i) &&
      $stable(done_res_i) && $stable(clock_out_i))
    else $error("stalled output word changed");

  // full output register with no taker blocks input, empty one takes input
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i |-> !in_ready_i) and (!out_valid_i |-> in_ready_i))
    else $error("input ready does not follow output register state");

  // done only at the end of a read high half
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && done_res_i |-> busy_res_i && clock_out_i && !data_drive_i)
    else $error("done outside a read high half");

  // idle pins
  a_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !busy_res_i |-> clock_out_i && data_drive_i && !data_out_i && !done_res_i)
    else $error("idle pin levels wrong");

  // released line never carries a driven one
  a_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !data_drive_i |-> !data_out_i && busy_res_i)
    else $error("released data line shows drive level");

endmodule

bind sensor_register_read_serial_master srsm_checker u_srsm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .clock_out_i  (out_o.clock_out),
  .data_out_i   (out_o.data_out),
  .data_drive_i (out_o.data_drive),
  .busy_res_i   (out_o.busy_res),
  .done_res_i   (out_o.done_res),
  .motion_i     (out_o.motion)
);
